### rtl/hba_pkg.sv
// Shared types and constants for the heap block allocator.
// Holds the table entry layout, request and status codes, controller states
// and the command and status bundles between controller and datapath.
`default_nettype none

package hba_pkg;

  // Heap size in bytes and default table depth.
  localparam int CAPACITY   = 512;
  localparam int MAX_BLOCKS = 64;

  // Field widths of the ports and internal byte arithmetic.
  localparam int BW   = 10;
  localparam int AW   = 9;
  localparam int OPW  = 3;
  localparam int STW  = 3;
  localparam int CNTW = 7;
  localparam int PCTW = 7;
  localparam int NW   = BW + PCTW;

  // Request codes.
  localparam logic [OPW-1:0] OP_BUMP  = OPW'(0);
  localparam logic [OPW-1:0] OP_FIRST = OPW'(1);
  localparam logic [OPW-1:0] OP_BEST  = OPW'(2);
  localparam logic [OPW-1:0] OP_SPLIT = OPW'(3);
  localparam logic [OPW-1:0] OP_FREE  = OPW'(4);

  // Result status codes.
  localparam logic [STW-1:0] ST_OK      = STW'(0);
  localparam logic [STW-1:0] ST_NOMEM   = STW'(1);
  localparam logic [STW-1:0] ST_BADADDR = STW'(2);
  localparam logic [STW-1:0] ST_ZERO    = STW'(3);
  localparam logic [STW-1:0] ST_FULL    = STW'(4);

  // One table entry.
  typedef struct packed {
    logic [BW-1:0] start;
    logic [BW-1:0] size;
    logic          used;
  } entry_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_FIXUP,
    S_STATS_GO,
    S_STATS,
    S_DIV_GO,
    S_DIV,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic in_scan;
    logic decide;
    logic in_move;
    logic fixup;
    logic stats_start;
    logic in_stats;
    logic div_start;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic fix_pending;
    logic div_done;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

### rtl/hba_ctrl.sv
// Controller state machine of the heap block allocator.
// Sequences scan, update, entry move, statistics and divide; uses hba_pkg.
`default_nettype none

module hba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hba_pkg::sts_t sts,
  output hba_pkg::cmd_t      cmd
);

  hba_pkg::state_t state;
  hba_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      hba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = hba_pkg::S_SCAN;
        end
      end
      hba_pkg::S_SCAN: begin
        cmd.in_scan = 1'b1;
        if (sts.walk_done) begin
          state_next = hba_pkg::S_DECIDE;
        end
      end
      hba_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = hba_pkg::S_MOVE;
      end
      hba_pkg::S_MOVE: begin
        cmd.in_move = 1'b1;
        if (sts.walk_done) begin
          state_next = sts.fix_pending ? hba_pkg::S_FIXUP : hba_pkg::S_STATS_GO;
        end
      end
      hba_pkg::S_FIXUP: begin
        cmd.fixup  = 1'b1;
        state_next = hba_pkg::S_STATS_GO;
      end
      hba_pkg::S_STATS_GO: begin
        cmd.stats_start = 1'b1;
        state_next      = hba_pkg::S_STATS;
      end
      hba_pkg::S_STATS: begin
        cmd.in_stats = 1'b1;
        if (sts.walk_done) begin
          state_next = hba_pkg::S_DIV_GO;
        end
      end
      hba_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = hba_pkg::S_DIV;
      end
      hba_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_next = hba_pkg::S_DONE;
        end
      end
      hba_pkg::S_DONE: begin
        if (!sts.out_full) begin
          cmd.publish = 1'b1;
          state_next  = hba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/hba_datapath.sv
// Datapath of the heap block allocator: block table memory, read walker,
// scan and statistics accumulators, update logic and percent divider; uses hba_pkg.
`default_nettype none

module hba_datapath #(
  parameter int MAX_BLOCKS = hba_pkg::MAX_BLOCKS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire hba_pkg::cmd_t              cmd,
  output hba_pkg::sts_t                   sts,
  input  wire logic [hba_pkg::OPW-1:0]    op,
  input  wire logic [hba_pkg::BW-1:0]     request_bytes,
  input  wire logic [hba_pkg::AW-1:0]     free_address,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hba_pkg::STW-1:0]         status,
  output logic [hba_pkg::AW-1:0]          block_start,
  output logic [hba_pkg::BW-1:0]          block_bytes,
  output logic [hba_pkg::BW-1:0]          bytes_in_use,
  output logic [hba_pkg::CNTW-1:0]        block_count,
  output logic [hba_pkg::CNTW-1:0]        used_block_count,
  output logic [hba_pkg::CNTW-1:0]        free_block_count,
  output logic [hba_pkg::PCTW-1:0]        fragmentation_pct
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int BW = hba_pkg::BW;
  localparam int NWL = hba_pkg::NW;
  localparam logic [BW-1:0] CAP = BW'(hba_pkg::CAPACITY);
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

  // Latched request.
  logic [hba_pkg::OPW-1:0] op_q;
  logic [BW-1:0]           req_q;
  logic [hba_pkg::AW-1:0]  addr_q;

  // Allocator state.
  logic [CW-1:0] entry_count;
  logic [BW-1:0] heap_end;
  logic [BW-1:0] used_total;

  // Table memory and its registered read port.
  hba_pkg::entry_t mem [MAX_BLOCKS];
  hba_pkg::entry_t rdata;
  logic            rvalid;
  logic [IW-1:0]   ridx;

  // Read walker.
  logic          rd_go;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] rd_end;
  logic          rd_dec;
  logic [1:0]    mv_dist;

  // Scan results.
  logic            first_hit, best_hit, m_hit;
  logic [IW-1:0]   first_idx, best_idx, m_idx;
  hba_pkg::entry_t first_e, best_e, m_e, prev_e, left_e, right_e;
  logic [BW-1:0]   best_slack;
  logic            left_ok, right_ok, right_want;

  // Pending remainder entry of a split.
  logic            fix_pending;
  logic [CW-1:0]   fix_idx;
  hba_pkg::entry_t fix_e;

  // Result of the update.
  logic [hba_pkg::STW-1:0] res_status;
  logic [BW-1:0]           res_start;
  logic [BW-1:0]           res_bytes;

  // Statistics.
  logic [CW-1:0] nused, nfree;
  logic [BW-1:0] big;

  // Divider.
  logic                     div_busy;
  logic [2:0]               div_cnt;
  logic [BW-1:0]            div_rem;
  logic [BW-1:0]            div_den;
  logic [hba_pkg::PCTW-1:0] div_lo;
  logic [hba_pkg::PCTW-1:0] div_q;
  logic                     div_zero;

  // Update decisions.
  logic                    zero_req, use_bump, bump_nomem, bump_full;
  logic                    sel_hit;
  logic [IW-1:0]           sel_idx;
  hba_pkg::entry_t         sel_e;
  logic                    mrg_l, mrg_r;
  logic [BW-1:0]           mrg_size;
  logic [hba_pkg::STW-1:0] d_status;
  logic [BW-1:0]           d_start, d_bytes, d_heap, d_used;
  logic [CW-1:0]           d_count;
  logic                    d_we;
  logic [CW-1:0]           d_waddr;
  hba_pkg::entry_t         d_wdata;
  logic                    d_walk, d_dec, d_fix;
  logic [CW-1:0]           d_from, d_to, d_fix_idx;
  logic [1:0]              d_dist;
  hba_pkg::entry_t         d_fix_e;

  // Memory write port.
  logic            we;
  logic [CW-1:0]   waddr;
  hba_pkg::entry_t wdata;

  // Scan helpers.
  logic          free_fit;
  logic [BW-1:0] fit_slack;

  // Divider helpers.
  logic [BW-1:0] fr_bytes;
  logic [NWL-1:0] num;
  logic [BW:0]   trial;

  assign zero_req   = (op_q <= hba_pkg::OP_SPLIT) && (req_q == '0);
  assign bump_nomem = req_q > (CAP - heap_end);
  assign bump_full  = entry_count >= MAXB;
  assign sel_hit    = (op_q == hba_pkg::OP_FIRST) ? first_hit : best_hit;
  assign sel_idx    = (op_q == hba_pkg::OP_FIRST) ? first_idx : best_idx;
  assign sel_e      = (op_q == hba_pkg::OP_FIRST) ? first_e : best_e;
  assign mrg_l      = left_ok && !left_e.used;
  assign mrg_r      = right_ok && !right_e.used;
  assign mrg_size   = m_e.size + (mrg_r ? right_e.size : '0) + (mrg_l ? left_e.size : '0);

  // Decide what one request does to the table.
  always_comb begin
    d_status  = hba_pkg::ST_OK;
    d_start   = '0;
    d_bytes   = '0;
    d_heap    = heap_end;
    d_used    = used_total;
    d_count   = entry_count;
    d_we      = 1'b0;
    d_waddr   = entry_count;
    d_wdata   = '0;
    d_walk    = 1'b0;
    d_dec     = 1'b0;
    d_from    = '0;
    d_to      = '0;
    d_dist    = 2'd1;
    d_fix     = 1'b0;
    d_fix_idx = '0;
    d_fix_e   = '0;
    use_bump  = 1'b0;
    if (zero_req) begin
      d_status = hba_pkg::ST_ZERO;
    end else begin
      case (op_q)
        hba_pkg::OP_BUMP: begin
          use_bump = 1'b1;
        end
        hba_pkg::OP_FIRST, hba_pkg::OP_BEST: begin
          if (sel_hit) begin
            d_we    = 1'b1;
            d_waddr = CW'(sel_idx);
            d_wdata = '{start: sel_e.start, size: sel_e.size, used: 1'b1};
            d_used  = used_total + sel_e.size;
            d_start = sel_e.start;
            d_bytes = sel_e.size;
          end else begin
            use_bump = 1'b1;
          end
        end
        hba_pkg::OP_SPLIT: begin
          if (!first_hit) begin
            use_bump = 1'b1;
          end else if (first_e.size == req_q) begin
            d_we    = 1'b1;
            d_waddr = CW'(first_idx);
            d_wdata = '{start: first_e.start, size: first_e.size, used: 1'b1};
            d_used  = used_total + req_q;
            d_start = first_e.start;
            d_bytes = req_q;
          end else if (bump_full) begin
            d_status = hba_pkg::ST_FULL;
          end else begin
            // Used head in place, entries above move up one, remainder after.
            d_we      = 1'b1;
            d_waddr   = CW'(first_idx);
            d_wdata   = '{start: first_e.start, size: req_q, used: 1'b1};
            d_used    = used_total + req_q;
            d_count   = entry_count + CW'(1);
            d_start   = first_e.start;
            d_bytes   = req_q;
            d_walk    = (CW'(first_idx) + CW'(1)) < entry_count;
            d_dec     = 1'b1;
            d_from    = entry_count - CW'(1);
            d_to      = CW'(first_idx) + CW'(1);
            d_fix     = 1'b1;
            d_fix_idx = CW'(first_idx) + CW'(1);
            d_fix_e   = '{start: first_e.start + req_q, size: first_e.size - req_q,
                          used: 1'b0};
          end
        end
        hba_pkg::OP_FREE: begin
          if (!m_hit || !m_e.used) begin
            d_status = hba_pkg::ST_BADADDR;
          end else begin
            // Merged block lands at the left neighbor when that one is free.
            d_we    = 1'b1;
            d_waddr = mrg_l ? (CW'(m_idx) - CW'(1)) : CW'(m_idx);
            d_wdata = '{start: (mrg_l ? left_e.start : m_e.start), size: mrg_size,
                        used: 1'b0};
            d_used  = used_total - m_e.size;
            d_count = entry_count - CW'(mrg_l) - CW'(mrg_r);
            d_start = mrg_l ? left_e.start : m_e.start;
            d_bytes = mrg_size;
            d_from  = CW'(m_idx) + CW'(1) + CW'(mrg_r);
            d_to    = entry_count - CW'(1);
            d_dist  = {1'b0, mrg_l} + {1'b0, mrg_r};
            d_walk  = (mrg_l || mrg_r) && (d_from < entry_count);
          end
        end
        default: begin
        end
      endcase
      if (use_bump) begin
        if (bump_nomem) begin
          d_status = hba_pkg::ST_NOMEM;
        end else if (bump_full) begin
          d_status = hba_pkg::ST_FULL;
        end else begin
          d_we    = 1'b1;
          d_waddr = entry_count;
          d_wdata = '{start: heap_end, size: req_q, used: 1'b1};
          d_count = entry_count + CW'(1);
          d_heap  = heap_end + req_q;
          d_used  = used_total + req_q;
          d_start = heap_end;
          d_bytes = req_q;
        end
      end
    end
  end

  // Write port select: update, entry move, or split remainder.
  always_comb begin
    we    = 1'b0;
    waddr = d_waddr;
    wdata = d_wdata;
    if (cmd.decide) begin
      we = d_we;
    end else if (cmd.in_move && rvalid) begin
      we    = 1'b1;
      waddr = rd_dec ? (CW'(ridx) + CW'(1)) : (CW'(ridx) - CW'(mv_dist));
      wdata = rdata;
    end else if (cmd.fixup) begin
      we    = 1'b1;
      waddr = fix_idx;
      wdata = fix_e;
    end
  end

  // Table memory.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
    if (rd_go) begin
      rdata <= mem[rd_ptr[IW-1:0]];
      ridx  <= rd_ptr[IW-1:0];
    end
  end

  // Read walker: one entry per cycle from rd_ptr to rd_end.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_go  <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= rd_go;
      if (cmd.scan_start || cmd.stats_start) begin
        rd_go  <= entry_count != '0;
        rd_ptr <= '0;
        rd_end <= entry_count - CW'(1);
        rd_dec <= 1'b0;
      end else if (cmd.decide) begin
        rd_go   <= d_walk;
        rd_ptr  <= d_from;
        rd_end  <= d_to;
        rd_dec  <= d_dec;
        mv_dist <= d_dist;
      end else if (rd_go) begin
        if (rd_ptr == rd_end) begin
          rd_go <= 1'b0;
        end else begin
          rd_ptr <= rd_dec ? (rd_ptr - CW'(1)) : (rd_ptr + CW'(1));
        end
      end
    end
  end

  // Request latch and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      heap_end    <= '0;
      used_total  <= '0;
      fix_pending <= 1'b0;
    end else begin
      if (cmd.decide) begin
        entry_count <= d_count;
        heap_end    <= d_heap;
        used_total  <= d_used;
        fix_pending <= d_fix;
      end else if (cmd.fixup) begin
        fix_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      req_q  <= request_bytes;
      addr_q <= free_address;
    end
    if (cmd.decide) begin
      res_status <= d_status;
      res_start  <= d_start;
      res_bytes  <= d_bytes;
      fix_idx    <= d_fix_idx;
      fix_e      <= d_fix_e;
    end
  end

  assign free_fit  = !rdata.used && (rdata.size >= req_q);
  assign fit_slack = rdata.size - req_q;

  // Search scan: first fit, best fit, address match and its neighbors.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      first_hit  <= 1'b0;
      best_hit   <= 1'b0;
      m_hit      <= 1'b0;
      left_ok    <= 1'b0;
      right_ok   <= 1'b0;
      right_want <= 1'b0;
    end else if (cmd.in_scan && rvalid) begin
      prev_e <= rdata;
      if (free_fit && !first_hit) begin
        first_hit <= 1'b1;
        first_idx <= ridx;
        first_e   <= rdata;
      end
      if (free_fit && (!best_hit || fit_slack < best_slack)) begin
        best_hit   <= 1'b1;
        best_idx   <= ridx;
        best_e     <= rdata;
        best_slack <= fit_slack;
      end
      if (right_want) begin
        right_ok   <= 1'b1;
        right_e    <= rdata;
        right_want <= 1'b0;
      end
      if (!m_hit && rdata.start == {1'b0, addr_q}) begin
        m_hit      <= 1'b1;
        m_idx      <= ridx;
        m_e        <= rdata;
        left_ok    <= ridx != '0;
        left_e     <= prev_e;
        right_want <= 1'b1;
      end
    end
  end

  // Statistics scan over the updated table.
  always_ff @(posedge clk) begin
    if (cmd.stats_start) begin
      nused <= '0;
      nfree <= '0;
      big   <= CAP - heap_end;
    end else if (cmd.in_stats && rvalid) begin
      if (rdata.used) begin
        nused <= nused + CW'(1);
      end else begin
        nfree <= nfree + CW'(1);
        if (rdata.size > big) begin
          big <= rdata.size;
        end
      end
    end
  end

  // Percent divider: restoring, one quotient bit a cycle.
  assign fr_bytes = CAP - used_total;
  assign num      = NWL'(fr_bytes - big) * NWL'(100);
  assign trial    = {div_rem, div_lo[hba_pkg::PCTW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == 3'd1) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_zero <= (fr_bytes == '0) || (big > fr_bytes);
      div_den  <= fr_bytes;
      div_rem  <= num[NWL-1:hba_pkg::PCTW];
      div_lo   <= num[hba_pkg::PCTW-1:0];
      div_q    <= '0;
      div_cnt  <= 3'(hba_pkg::PCTW);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 3'd1;
      div_lo  <= {div_lo[hba_pkg::PCTW-2:0], 1'b0};
      if (trial >= {1'b0, div_den}) begin
        div_rem <= BW'(trial - {1'b0, div_den});
        div_q   <= {div_q[hba_pkg::PCTW-2:0], 1'b1};
      end else begin
        div_rem <= trial[BW-1:0];
        div_q   <= {div_q[hba_pkg::PCTW-2:0], 1'b0};
      end
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status            <= res_status;
      block_start       <= res_start[hba_pkg::AW-1:0];
      block_bytes       <= res_bytes;
      bytes_in_use      <= used_total;
      block_count       <= hba_pkg::CNTW'(entry_count);
      used_block_count  <= hba_pkg::CNTW'(nused);
      free_block_count  <= hba_pkg::CNTW'(nfree);
      fragmentation_pct <= div_zero ? '0 : div_q;
    end
  end

  assign sts.walk_done   = !rd_go && !rvalid;
  assign sts.fix_pending = fix_pending;
  assign sts.div_done    = !div_busy;
  assign sts.out_full    = out_valid && !out_ready;

endmodule

`default_nettype wire

### rtl/heap_block_allocator_unit.sv
// Top level of the heap block allocator.
// Joins the controller (hba_ctrl) and the datapath (hba_datapath); uses hba_pkg.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_ready  op, request_bytes, free_address
//   out      out_valid/ out_ready status, block_start, block_bytes, bytes_in_use,
//                                 block_count, used_block_count, free_block_count,
//                                 fragmentation_pct
//
// A request runs a search scan over the table, the update, a move of the entries
// that shift on a split or merge, a write of a split remainder, a count scan
// of the updated table, the percent divider and the result state. The table
// memory has one read and one write port, which sets the pass lengths. A
// stalled output holds the controller in the result state until the stall ends.
// Reset (rst, synchronous) empties the table at once; no clearing pass.
// The next transfer is taken while a result still waits in the output register.
`default_nettype none

module heap_block_allocator_unit #(
  parameter int MAX_BLOCKS = hba_pkg::MAX_BLOCKS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [hba_pkg::OPW-1:0]   op,
  input  wire logic [hba_pkg::BW-1:0]    request_bytes,
  input  wire logic [hba_pkg::AW-1:0]    free_address,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [hba_pkg::STW-1:0]        status,
  output logic [hba_pkg::AW-1:0]         block_start,
  output logic [hba_pkg::BW-1:0]         block_bytes,
  output logic [hba_pkg::BW-1:0]         bytes_in_use,
  output logic [hba_pkg::CNTW-1:0]       block_count,
  output logic [hba_pkg::CNTW-1:0]       used_block_count,
  output logic [hba_pkg::CNTW-1:0]       free_block_count,
  output logic [hba_pkg::PCTW-1:0]       fragmentation_pct
);

  hba_pkg::cmd_t cmd;
  hba_pkg::sts_t sts;

  // Sequencing.
  hba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, arithmetic and result register.
  hba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .op                (op),
    .request_bytes     (request_bytes),
    .free_address      (free_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .block_start       (block_start),
    .block_bytes       (block_bytes),
    .bytes_in_use      (bytes_in_use),
    .block_count       (block_count),
    .used_block_count  (used_block_count),
    .free_block_count  (free_block_count),
    .fragmentation_pct (fragmentation_pct)
  );

endmodule

`default_nettype wire
